/* hdl/slp_pkg.sv */
package slp_pkg;

    localparam int ROWS        = 16;
    localparam int COLS        = 32;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 5;
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int DEPTH       = ROWS * COLS;
    localparam int PIVOT_LIMIT = 1024;
    localparam int BUDGET_W    = 11;
    localparam int IDX_W       = 2;
    localparam int CFG_W       = 16;
    localparam int TOL_W       = 16;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;
    localparam int OBJ_W       = 32;

    localparam logic [63:0] FX_ONE = 64'h0000_0001_0000_0000;
    localparam logic [63:0] FX_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FX_MIN = 64'h8000_0000_0000_0000;

    localparam logic [IDX_W-1:0] CFG_M   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_N   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_TOL = 2'd2;

    typedef enum logic [1:0] {
        ST_OPTIMAL    = 2'd0,
        ST_INFEASIBLE = 2'd1,
        ST_UNBOUNDED  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        WR_IN   = 3'd0,
        WR_ONE  = 3'd1,
        WR_ZERO = 3'd2,
        WR_DIV  = 3'd3,
        WR_SUB  = 3'd4
    } t_wr_sel;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic [COL_W-1:0] rd_col;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [COL_W-1:0] wr_col;
        t_wr_sel          wr_sel;
        logic             ld_den;
        logic             ld_x;
        logic             ld_best;
        logic             ld_neg;
        logic             div_start;
        logic             mul_start;
        logic             ld_out;
        t_status          out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic lt_neg;
        logic gt_tol;
        logic mag_gt;
        logic ratio_lt;
        logic div_done;
        logic mul_done;
        logic out_valid;
    } t_dp_stat;

    function automatic logic [63:0] mag64(input logic [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m,
                                             input logic ovf);
        if (neg) begin
            return (ovf || m[63]) ? FX_MIN : (~m + 64'd1);
        end
        return (ovf || m[63]) ? FX_MAX : m;
    endfunction

    function automatic logic [63:0] fx_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        if (a[63] != b[63] && d[63] != a[63]) begin
            return a[63] ? FX_MIN : FX_MAX;
        end
        return d;
    endfunction

    function automatic logic [63:0] neg_sat(input logic [63:0] v);
        return (v == FX_MIN) ? FX_MAX : (~v + 64'd1);
    endfunction

    // v is the negated corner; round half up to an integer, saturate at the top
    function automatic logic [OBJ_W-1:0] round_obj(input logic [63:0] v);
        logic [63:0] u;
        logic [32:0] hi;
        u  = {~v[63], v[62:0]};
        hi = {1'b0, u[63:32]} + 33'(u[31]);
        return hi[32] ? 32'h7FFF_FFFF : (hi[31:0] ^ 32'h8000_0000);
    endfunction

endpackage

/* hdl/simplex_lp_solver_core.sv */
// Entry writes: one word per cycle while idle, no result.
// Solve: up to 1024 pivots; each division uses a bit-serial divider, each
// product a 32x32 multiplier, with one tableau access per cycle.
// The result sits in an output register; a solve waits until it is taken.
// Reset: a pass over all 512 entries zeroes the tableau with s_tready low; config 15/31/43.
module simplex_lp_solver_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [slp_pkg::IN_TDATA_W-1:0]  s_tdata,   // row[3:0], col[8:4], value[72:9]
    input  logic [0:0]                      s_tuser,   // kind[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [slp_pkg::OUT_TDATA_W-1:0] m_tdata,   // status[1:0], objective[33:2]
    input  logic                            i_cfg_we,
    input  logic [slp_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [slp_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import slp_pkg::*;

    logic [ROW_W-1:0] r_m;
    logic [COL_W-1:0] r_n;
    logic [TOL_W-1:0] r_tol;

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [1:0]       status;
    logic [OBJ_W-1:0] objective;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m   <= 4'd15;
            r_n   <= 5'd31;
            r_tol <= 16'd43;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_M:   r_m   <= i_cfg_wdata[ROW_W-1:0];
                CFG_N:   r_n   <= i_cfg_wdata[COL_W-1:0];
                CFG_TOL: r_tol <= i_cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    slp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_kind  (s_tuser[0]),
        .i_row   (s_tdata[3:0]),
        .i_col   (s_tdata[8:4]),
        .i_m     (r_m),
        .i_n     (r_n),
        .i_stat  (stat),
        .o_ready (s_tready),
        .o_cmd   (cmd)
    );

    slp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (s_tdata[72:9]),
        .i_tol       (r_tol),
        .i_out_ready (m_tready),
        .o_stat      (stat),
        .o_status    (status),
        .o_objective (objective)
    );

    assign m_tvalid = stat.out_valid;
    assign m_tdata  = {6'd0, objective, status};

    a_solve_needs_empty_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |-> !m_tvalid)
        else $error("solve accepted while a result is pending");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_tready)
        else $error("input ready during tableau clear");

    a_objective_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[1:0] != ST_OPTIMAL) |-> m_tdata[33:2] == 32'd0)
        else $error("objective nonzero on a non-optimal result");

endmodule

/* hdl/slp_div.sv */
module slp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_q
);
    import slp_pkg::*;

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_RUN  = 5'b00010,
        D_RND  = 5'b00100,
        D_INC  = 5'b01000,
        D_FIN  = 5'b10000
    } t_dstate;

    t_dstate      r_state;
    logic [6:0]   r_cnt;
    logic [127:0] r_num;
    logic [63:0]  r_rem;
    logic [63:0]  r_q;
    logic [63:0]  r_ub;
    logic [63:0]  r_res;
    logic         r_ovf;
    logic         r_neg;
    logic         r_asign;
    logic         r_az;
    logic         r_bz;
    logic         r_rnd;
    logic         r_done;

    logic [63:0] rs;
    logic        take;
    logic [63:0] n_rem;

    // one quotient bit per cycle, restoring
    always_comb begin
        rs    = {r_rem[62:0], r_num[127]};
        take  = r_rem[63] || (rs >= r_ub);
        n_rem = take ? (rs - r_ub) : rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_num   <= {32'd0, mag64(i_a), 32'd0};
                        r_ub    <= mag64(i_b);
                        r_neg   <= i_a[63] ^ i_b[63];
                        r_asign <= i_a[63];
                        r_az    <= (i_a == 64'd0);
                        r_bz    <= (i_b == 64'd0);
                        r_rem   <= 64'd0;
                        r_q     <= 64'd0;
                        r_ovf   <= 1'b0;
                        r_cnt   <= 7'd0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_num <= {r_num[126:0], 1'b0};
                    r_rem <= n_rem;
                    r_q   <= {r_q[62:0], take};
                    if (r_q[63]) begin
                        r_ovf <= 1'b1;
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_state <= D_RND;
                    end
                end
                D_RND: begin
                    r_rnd   <= (r_rem >= (r_ub - r_rem));
                    r_state <= D_INC;
                end
                D_INC: begin
                    r_q <= r_q + 64'(r_rnd);
                    if (r_rnd && r_q == '1) begin
                        r_ovf <= 1'b1;
                    end
                    r_state <= D_FIN;
                end
                D_FIN: begin
                    if (r_bz) begin
                        r_res <= r_az ? 64'd0 : (r_asign ? FX_MIN : FX_MAX);
                    end else begin
                        r_res <= from_mag(r_neg, r_q, r_ovf);
                    end
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;

endmodule

/* hdl/slp_mul.sv */
module slp_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_q
);
    import slp_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_PP   = 4'b0010,
        M_RND  = 4'b0100,
        M_FIN  = 4'b1000
    } t_mstate;

    t_mstate      r_state;
    logic [2:0]   r_k;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic [63:0]  r_pp;
    logic [127:0] r_acc;
    logic [63:0]  r_r;
    logic [63:0]  r_res;
    logic         r_ovf;
    logic         r_neg;
    logic         r_done;

    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [63:0]  pp;
    logic [1:0]   prev;
    logic [127:0] pp_sh;
    logic [64:0]  sum;

    always_comb begin
        op_a = r_k[1] ? r_ua[63:32] : r_ua[31:0];
        op_b = (r_k[1:0] == 2'd1 || r_k[1:0] == 2'd3) ? r_ub[63:32] : r_ub[31:0];
        pp   = op_a * op_b;
        prev = 2'(r_k - 3'd1);
        case (prev)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd3:    pp_sh = {r_pp, 64'd0};
            default: pp_sh = {32'd0, r_pp, 32'd0};
        endcase
        sum = {1'b0, r_acc[95:32]} + 65'(r_acc[31]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_ua    <= mag64(i_a);
                        r_ub    <= mag64(i_b);
                        r_neg   <= i_a[63] ^ i_b[63];
                        r_acc   <= 128'd0;
                        r_k     <= 3'd0;
                        r_state <= M_PP;
                    end
                end
                M_PP: begin
                    // partial product in, previous one into the accumulator
                    if (!r_k[2]) begin
                        r_pp <= pp;
                    end
                    if (r_k != 3'd0) begin
                        r_acc <= r_acc + pp_sh;
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k[2]) begin
                        r_state <= M_RND;
                    end
                end
                M_RND: begin
                    r_r     <= sum[63:0];
                    r_ovf   <= (r_acc[127:96] != 32'd0) || sum[64];
                    r_state <= M_FIN;
                end
                M_FIN: begin
                    r_res   <= from_mag(r_neg, r_r, r_ovf);
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;

endmodule

/* hdl/slp_dp.sv */
module slp_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  slp_pkg::t_dp_cmd        i_cmd,
    input  logic [63:0]             i_value,
    input  logic [slp_pkg::TOL_W-1:0] i_tol,
    input  logic                    i_out_ready,
    output slp_pkg::t_dp_stat       o_stat,
    output logic [1:0]              o_status,
    output logic [slp_pkg::OBJ_W-1:0] o_objective
);
    import slp_pkg::*;

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;
    logic [63:0] r_den;
    logic [63:0] r_x;
    logic [63:0] r_best;
    logic        r_ovalid;
    logic [1:0]  r_ostatus;
    logic [OBJ_W-1:0] r_oobj;

    logic [63:0] wdata;
    logic [63:0] tol64;
    logic        div_done;
    logic [63:0] div_q;
    logic        mul_done;
    logic [63:0] mul_q;

    slp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_a     (r_rdata),
        .i_b     (r_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    slp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (r_rdata),
        .i_b     (r_x),
        .o_done  (mul_done),
        .o_q     (mul_q)
    );

    always_comb begin
        case (i_cmd.wr_sel)
            WR_IN:   wdata = i_value;
            WR_ONE:  wdata = FX_ONE;
            WR_ZERO: wdata = 64'd0;
            WR_DIV:  wdata = div_q;
            WR_SUB:  wdata = fx_sub(r_rdata, mul_q);
            default: wdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[{i_cmd.wr_row, i_cmd.wr_col}] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[{i_cmd.rd_row, i_cmd.rd_col}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_den) begin
            r_den <= r_rdata;
        end
        if (i_cmd.ld_x) begin
            r_x <= r_rdata;
        end else if (i_cmd.ld_neg) begin
            r_x <= neg_sat(r_rdata);
        end
        if (i_cmd.ld_best) begin
            r_best <= div_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.ld_out) begin
                r_ovalid  <= 1'b1;
                r_ostatus <= i_cmd.out_status;
                r_oobj    <= (i_cmd.out_status == ST_OPTIMAL) ? round_obj(r_x) : '0;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign tol64 = {48'd0, i_tol};

    always_comb begin
        o_stat.lt_neg    = $signed(r_rdata) < -$signed(tol64);
        o_stat.gt_tol    = $signed(r_rdata) > $signed(tol64);
        o_stat.mag_gt    = mag64(r_rdata) > tol64;
        o_stat.ratio_lt  = $signed(div_q) < $signed(r_best);
        o_stat.div_done  = div_done;
        o_stat.mul_done  = mul_done;
        o_stat.out_valid = r_ovalid;
    end

    assign o_status    = r_ostatus;
    assign o_objective = r_oobj;

endmodule

/* hdl/slp_ctrl.sv */
module slp_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_kind,
    input  logic [slp_pkg::ROW_W-1:0] i_row,
    input  logic [slp_pkg::COL_W-1:0] i_col,
    input  logic [slp_pkg::ROW_W-1:0] i_m,
    input  logic [slp_pkg::COL_W-1:0] i_n,
    input  slp_pkg::t_dp_stat         i_stat,
    output logic                      o_ready,
    output slp_pkg::t_dp_cmd          o_cmd
);
    import slp_pkg::*;

    typedef enum logic [25:0] {
        S_CLR   = 26'b00000000000000000000000001,
        S_IDLE  = 26'b00000000000000000000000010,
        S_F_RD  = 26'b00000000000000000000000100,
        S_F_CK  = 26'b00000000000000000000001000,
        S_F_CRD = 26'b00000000000000000000010000,
        S_F_CCK = 26'b00000000000000000000100000,
        S_O_ERD = 26'b00000000000000000001000000,
        S_O_ECK = 26'b00000000000000000010000000,
        S_O_RRD = 26'b00000000000000000100000000,
        S_O_RCK = 26'b00000000000000001000000000,
        S_O_DST = 26'b00000000000000010000000000,
        S_O_DWT = 26'b00000000000000100000000000,
        S_P_RD  = 26'b00000000000001000000000000,
        S_P_LD  = 26'b00000000000010000000000000,
        S_P_DRD = 26'b00000000000100000000000000,
        S_P_DST = 26'b00000000001000000000000000,
        S_P_DWT = 26'b00000000010000000000000000,
        S_E_RD  = 26'b00000000100000000000000000,
        S_E_CK  = 26'b00000001000000000000000000,
        S_E_PRD = 26'b00000010000000000000000000,
        S_E_MST = 26'b00000100000000000000000000,
        S_E_MWT = 26'b00001000000000000000000000,
        S_E_WR  = 26'b00010000000000000000000000,
        S_R_RD  = 26'b00100000000000000000000000,
        S_R_NEG = 26'b01000000000000000000000000,
        S_R_OUT = 26'b10000000000000000000000000
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic [ROW_W:0]      r_i, n_i;
    logic [COL_W:0]      r_j, n_j;
    logic [ROW_W-1:0]    r_l, n_l;
    logic [COL_W-1:0]    r_e, n_e;
    logic [BUDGET_W-1:0] r_budget, n_budget;
    logic                r_first, n_first;
    logic                r_opt, n_opt;
    t_status             r_status, n_status;

    logic i_done;
    logic j_done;
    logic accept;

    assign i_done  = r_i > {1'b0, i_m};
    assign j_done  = r_j > {1'b0, i_n};
    assign o_ready = (r_state == S_IDLE) && (!i_kind || !i_stat.out_valid);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_i      = r_i;
        n_j      = r_j;
        n_l      = r_l;
        n_e      = r_e;
        n_budget = r_budget;
        n_first  = r_first;
        n_opt    = r_opt;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_row = r_clr[ADDR_W-1:COL_W];
                o_cmd.wr_col = r_clr[COL_W-1:0];
                o_cmd.wr_sel = WR_ZERO;
                n_clr        = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (!i_kind) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_row = i_row;
                        o_cmd.wr_col = i_col;
                        o_cmd.wr_sel = WR_IN;
                    end else begin
                        n_i      = (ROW_W+1)'(1);
                        n_budget = BUDGET_W'(PIVOT_LIMIT);
                        n_opt    = 1'b0;
                        n_state  = S_F_RD;
                    end
                end
            end
            // feasibility: lowest row with a right-hand side below minus the tolerance
            S_F_RD: begin
                if (i_done) begin
                    n_j     = (COL_W+1)'(1);
                    n_opt   = 1'b1;
                    n_state = S_O_ERD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_row = r_i[ROW_W-1:0];
                    n_state      = S_F_CK;
                end
            end
            S_F_CK: begin
                if (i_stat.lt_neg) begin
                    n_l     = r_i[ROW_W-1:0];
                    n_j     = (COL_W+1)'(1);
                    n_state = S_F_CRD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_F_RD;
                end
            end
            S_F_CRD: begin
                if (j_done) begin
                    n_status = ST_INFEASIBLE;
                    n_state  = S_R_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_row = r_l;
                    o_cmd.rd_col = r_j[COL_W-1:0];
                    n_state      = S_F_CCK;
                end
            end
            S_F_CCK: begin
                if (i_stat.lt_neg) begin
                    n_e = r_j[COL_W-1:0];
                    if (r_budget == '0) begin
                        n_status = ST_INFEASIBLE;
                        n_state  = S_R_RD;
                    end else begin
                        n_budget = r_budget - 1'b1;
                        n_state  = S_P_RD;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_F_CRD;
                end
            end
            // optimization: lowest column with an objective entry above the tolerance enters
            S_O_ERD: begin
                if (j_done) begin
                    n_status = ST_OPTIMAL;
                    n_state  = S_R_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_col = r_j[COL_W-1:0];
                    n_state      = S_O_ECK;
                end
            end
            S_O_ECK: begin
                if (i_stat.gt_tol) begin
                    n_e     = r_j[COL_W-1:0];
                    n_i     = (ROW_W+1)'(1);
                    n_first = 1'b1;
                    n_state = S_O_RRD;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_O_ERD;
                end
            end
            S_O_RRD: begin
                if (i_done) begin
                    if (r_first || r_budget == '0) begin
                        n_status = ST_UNBOUNDED;
                        n_state  = S_R_RD;
                    end else begin
                        n_budget = r_budget - 1'b1;
                        n_state  = S_P_RD;
                    end
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_row = r_i[ROW_W-1:0];
                    o_cmd.rd_col = r_e;
                    n_state      = S_O_RCK;
                end
            end
            S_O_RCK: begin
                if (i_stat.gt_tol) begin
                    o_cmd.ld_den = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_row = r_i[ROW_W-1:0];
                    n_state      = S_O_DST;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_O_RRD;
                end
            end
            S_O_DST: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_O_DWT;
            end
            S_O_DWT: begin
                if (i_stat.div_done) begin
                    // strict compare keeps the lowest row on a tie
                    if (r_first || i_stat.ratio_lt) begin
                        o_cmd.ld_best = 1'b1;
                        n_l           = r_i[ROW_W-1:0];
                        n_first       = 1'b0;
                    end
                    n_i     = r_i + 1'b1;
                    n_state = S_O_RRD;
                end
            end
            // pivot: scale the pivot row
            S_P_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_row = r_l;
                o_cmd.rd_col = r_e;
                n_state      = S_P_LD;
            end
            S_P_LD: begin
                o_cmd.ld_den = 1'b1;
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_row = r_l;
                o_cmd.wr_col = r_e;
                o_cmd.wr_sel = WR_ONE;
                n_j          = '0;
                n_state      = S_P_DRD;
            end
            S_P_DRD: begin
                if (j_done) begin
                    n_i     = '0;
                    n_state = S_E_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_row = r_l;
                    o_cmd.rd_col = r_j[COL_W-1:0];
                    n_state      = S_P_DST;
                end
            end
            S_P_DST: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_P_DWT;
            end
            S_P_DWT: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_row = r_l;
                    o_cmd.wr_col = r_j[COL_W-1:0];
                    o_cmd.wr_sel = WR_DIV;
                    n_j          = r_j + 1'b1;
                    n_state      = S_P_DRD;
                end
            end
            // pivot: eliminate the entering column from the other rows
            S_E_RD: begin
                if (i_done) begin
                    if (r_opt) begin
                        n_j     = (COL_W+1)'(1);
                        n_state = S_O_ERD;
                    end else begin
                        n_i     = (ROW_W+1)'(1);
                        n_state = S_F_RD;
                    end
                end else if (r_i[ROW_W-1:0] == r_l) begin
                    n_i = r_i + 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_row = r_i[ROW_W-1:0];
                    o_cmd.rd_col = r_e;
                    n_state      = S_E_CK;
                end
            end
            S_E_CK: begin
                if (i_stat.mag_gt) begin
                    o_cmd.ld_x   = 1'b1;
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_row = r_i[ROW_W-1:0];
                    o_cmd.wr_col = r_e;
                    o_cmd.wr_sel = WR_ZERO;
                    n_j          = '0;
                    n_state      = S_E_PRD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_E_RD;
                end
            end
            S_E_PRD: begin
                if (j_done) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_E_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_row = r_l;
                    o_cmd.rd_col = r_j[COL_W-1:0];
                    n_state      = S_E_MST;
                end
            end
            S_E_MST: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_E_MWT;
            end
            S_E_MWT: begin
                if (i_stat.mul_done) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_row = r_i[ROW_W-1:0];
                    o_cmd.rd_col = r_j[COL_W-1:0];
                    n_state      = S_E_WR;
                end
            end
            S_E_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_row = r_i[ROW_W-1:0];
                o_cmd.wr_col = r_j[COL_W-1:0];
                o_cmd.wr_sel = WR_SUB;
                n_j          = r_j + 1'b1;
                n_state      = S_E_PRD;
            end
            // result: fetch the corner, negate, round
            S_R_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_R_NEG;
            end
            S_R_NEG: begin
                o_cmd.ld_neg = 1'b1;
                n_state      = S_R_OUT;
            end
            S_R_OUT: begin
                o_cmd.ld_out     = 1'b1;
                o_cmd.out_status = r_status;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_budget <= '0;
            r_first  <= 1'b0;
            r_opt    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_i      <= n_i;
            r_j      <= n_j;
            r_budget <= n_budget;
            r_first  <= n_first;
            r_opt    <= n_opt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l      <= n_l;
        r_e      <= n_e;
        r_status <= n_status;
    end

endmodule

/* verif/tb_top.sv */
module tb_top;
    import slp_pkg::*;

    localparam longint CYCLE_LIMIT = 600_000_000;
    localparam int     ITEM_GOAL   = 950;
    localparam int     DRAIN_WAIT  = 200;
    localparam int     HOLD_LEN    = 30000;

    typedef struct {
        bit          kind;
        logic [3:0]  row;
        logic [4:0]  col;
        logic [63:0] value;
    } t_item;

    typedef struct {
        t_status     status;
        logic [31:0] objective;
    } t_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   i_cfg_we;
    logic [IDX_W-1:0]       i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_wdata;

    simplex_lp_solver_core dut (.*);

    // shadow of the solver state
    logic [63:0] lp_tab [ROWS][COLS];
    int          lp_rows, lp_cols;
    logic [63:0] lp_tol;

    t_item   word_q[$];
    t_result solution_q[$];
    int      errors;
    int      items_queued;
    int      idle_pct, stall_pct;
    int      hold_req, hold_seen, hold_left;
    bit      word_taken;
    longint  cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] abs_mag(logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] clamp_signed(bit neg, logic [63:0] mag, bit ovf);
        if (neg) return (ovf || mag[63]) ? FX_MIN : (64'd0 - mag);
        return (ovf || mag[63]) ? FX_MAX : mag;
    endfunction

    function automatic logic [63:0] sat_minus(logic [63:0] a, logic [63:0] b);
        logic [64:0] d;
        d = {a[63], a} - {b[63], b};
        if (d[64] != d[63]) return d[64] ? FX_MIN : FX_MAX;
        return d[63:0];
    endfunction

    function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        logic [64:0]  r;
        p = {64'd0, abs_mag(a)} * {64'd0, abs_mag(b)};
        r = {1'b0, p[95:32]} + 65'(p[31]);
        return clamp_signed(a[63] ^ b[63], r[63:0], (p[127:96] != 0) || r[64]);
    endfunction

    function automatic logic [63:0] q_div(logic [63:0] a, logic [63:0] b);
        logic [127:0] num, quo, rem;
        logic [63:0]  ub, q;
        bit           ovf;
        ub = abs_mag(b);
        if (ub == 0) return (a == 0) ? 64'd0 : (a[63] ? FX_MIN : FX_MAX);
        num = {32'd0, abs_mag(a), 32'd0};
        quo = num / {64'd0, ub};
        rem = num % {64'd0, ub};
        ovf = quo[127:64] != 0;
        q   = quo[63:0];
        if (rem[63:0] >= ub - rem[63:0]) begin
            q = q + 64'd1;
            if (q == 0) ovf = 1;
        end
        return clamp_signed(a[63] ^ b[63], q, ovf);
    endfunction

    function automatic void lp_pivot(int l, int e);
        logic [63:0] p, x;
        p = lp_tab[l][e];
        lp_tab[l][e] = FX_ONE;
        for (int j = 0; j <= lp_cols; j++) lp_tab[l][j] = q_div(lp_tab[l][j], p);
        for (int i = 0; i <= lp_rows; i++) begin
            x = lp_tab[i][e];
            if (i != l && abs_mag(x) > lp_tol) begin
                lp_tab[i][e] = 0;
                for (int j = 0; j <= lp_cols; j++)
                    lp_tab[i][j] = sat_minus(lp_tab[i][j], q_mul(lp_tab[l][j], x));
            end
        end
    endfunction

    function automatic t_status lp_solve();
        int          budget, l, e;
        logic [63:0] best, r;
        longint      neg_tol, pos_tol;
        budget  = PIVOT_LIMIT;
        pos_tol = longint'(lp_tol);
        neg_tol = -pos_tol;
        forever begin
            l = 0;
            for (int i = 1; i <= lp_rows && l == 0; i++)
                if ($signed(lp_tab[i][0]) < neg_tol) l = i;
            if (l == 0) break;
            e = 0;
            for (int i = 1; i <= lp_cols && e == 0; i++)
                if ($signed(lp_tab[l][i]) < neg_tol) e = i;
            if (e == 0 || budget == 0) return ST_INFEASIBLE;
            budget--;
            lp_pivot(l, e);
        end
        forever begin
            e = 0;
            for (int i = 1; i <= lp_cols && e == 0; i++)
                if ($signed(lp_tab[0][i]) > pos_tol) e = i;
            if (e == 0) break;
            l = 0;
            best = 0;
            for (int i = 1; i <= lp_rows; i++) begin
                if ($signed(lp_tab[i][e]) > pos_tol) begin
                    r = q_div(lp_tab[i][0], lp_tab[i][e]);
                    if (l == 0 || $signed(r) < $signed(best)) begin
                        best = r;
                        l = i;
                    end
                end
            end
            if (l == 0 || budget == 0) return ST_UNBOUNDED;
            budget--;
            lp_pivot(l, e);
        end
        return ST_OPTIMAL;
    endfunction

    function automatic logic [31:0] lp_objective();
        logic [63:0] v;
        longint      whole;
        v = (lp_tab[0][0] == FX_MIN) ? FX_MAX : (64'd0 - lp_tab[0][0]);
        // floor(v + 0.5) on the signed value
        whole = ($signed(v) >>> 32) + longint'(v[31]);
        if (whole > 64'sd2147483647) whole = 64'sd2147483647;
        return whole[31:0];
    endfunction

    function automatic void apply_word(t_item it);
        t_result res;
        if (!it.kind) begin
            lp_tab[it.row][it.col] = it.value;
        end else begin
            res.status    = lp_solve();
            res.objective = (res.status == ST_OPTIMAL) ? lp_objective() : 32'd0;
            solution_q.push_back(res);
        end
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || word_taken)) begin
            if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, word_q[0].value, word_q[0].col, word_q[0].row};
                s_tuser  <= word_q[0].kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        word_taken = 0;
    end

    // receiver with a single long hold-off
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= i_rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result expd;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n && s_tvalid && s_tready) begin
            apply_word(word_q.pop_front());
            word_taken = 1;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            if (solution_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: actual status %0d objective %0d",
                         $time, m_tdata[1:0], $signed(m_tdata[33:2]));
            end else begin
                expd = solution_q.pop_front();
                if (m_tdata[1:0] !== expd.status) begin
                    errors++;
                    $display("%0t status: expected %0d actual %0d",
                             $time, expd.status, m_tdata[1:0]);
                end
                if (m_tdata[33:2] !== expd.objective) begin
                    errors++;
                    $display("%0t objective: expected %0d actual %0d",
                             $time, $signed(expd.objective), $signed(m_tdata[33:2]));
                end
            end
        end
    end

    task automatic push_word(int kind, int row, int col, logic [63:0] value);
        t_item it;
        it.kind  = (kind != 0);
        it.row   = 4'(row);
        it.col   = 5'(col);
        it.value = value;
        word_q.push_back(it);
        items_queued++;
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, int data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_M:   lp_rows = data & 15;
            CFG_N:   lp_cols = data & 31;
            CFG_TOL: lp_tol  = 64'(data & 16'hFFFF);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || s_tvalid || solution_q.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [63:0] small_fx(int lo, int hi);
        logic [63:0] v;
        v = 64'($signed(lo + int'($urandom_range(hi - lo)))) << 32;
        if ($urandom_range(3) == 0) v[31:0] = $urandom();
        return v;
    endfunction

    // one problem over the rows and columns in use, then a solve
    task automatic push_problem(int rows, int cols);
        bit noisy;
        noisy = $urandom_range(9) == 0;
        for (int r = 0; r <= rows; r++)
            for (int c = 0; c <= cols; c++) begin
                if (noisy && $urandom_range(2) == 0)
                    push_word(0, r, c, {$urandom(), $urandom()});
                else if (r == 0)
                    push_word(0, r, c, small_fx(-6, 6));
                else if (c == 0)
                    push_word(0, r, c, small_fx($urandom_range(3) == 0 ? -8 : 0, 20));
                else
                    push_word(0, r, c, small_fx(-5, 9));
            end
        // a stray word at a random position, possibly outside the area in use
        if ($urandom_range(2) == 0)
            push_word(0, $urandom_range(15), $urandom_range(31), {$urandom(), $urandom()});
        push_word(1, $urandom_range(15), $urandom_range(31), {$urandom(), $urandom()});
    endtask

    initial begin
        int prof;
        errors = 0; items_queued = 0; cycles = 0;
        idle_pct = 0; stall_pct = 0;
        hold_req = 0; hold_seen = 0; hold_left = 0;
        word_taken = 0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        m_tready = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_wdata = '0;
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++) lp_tab[r][c] = 0;
        lp_rows = 15; lp_cols = 31; lp_tol = 64'd43;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);

        // full size: empty tableau, then extreme corners
        cfg_write(CFG_M, 15);
        cfg_write(CFG_N, 31);
        cfg_write(CFG_TOL, 43);
        push_word(1, 0, 0, 64'd0);
        push_word(0, 0, 0, FX_MIN);
        push_word(0, 15, 31, FX_MAX);
        push_word(1, 15, 31, FX_MAX);
        push_word(0, 0, 0, FX_MAX);
        push_word(1, 0, 0, 64'd0);
        push_word(0, 0, 0, 64'hFFFF_FFFF_8000_0000);
        push_word(1, 0, 0, 64'd0);
        push_word(0, 15, 31, 64'd0);
        wait_idle();

        // single row and column: infeasible, unbounded, one clean pivot
        cfg_write(CFG_M, 1);
        cfg_write(CFG_N, 1);
        cfg_write(CFG_TOL, 0);
        push_word(0, 0, 0, 64'd0);
        push_word(0, 1, 0, -FX_ONE);
        push_word(0, 1, 1, FX_ONE);
        push_word(1, 0, 0, 64'd0);
        push_word(0, 0, 0, 64'd0);
        push_word(0, 0, 1, FX_ONE);
        push_word(0, 1, 0, FX_ONE);
        push_word(0, 1, 1, -FX_ONE);
        push_word(1, 0, 0, 64'd0);
        push_word(0, 0, 0, 64'd0);
        push_word(0, 0, 1, 64'd3 << 32);
        push_word(0, 1, 0, 64'd4 << 32);
        push_word(0, 1, 1, 64'd2 << 32);
        push_word(1, 0, 0, 64'd0);
        wait_idle();

        // random problems under changing settings and traffic profiles
        prof = 0;
        while (items_queued < ITEM_GOAL) begin
            cfg_write(CFG_M, $urandom_range(1, 3));
            cfg_write(CFG_N, $urandom_range(1, 3));
            case ($urandom_range(3))
                0: cfg_write(CFG_TOL, 0);
                1: cfg_write(CFG_TOL, 65535);
                default: cfg_write(CFG_TOL, $urandom_range(65535));
            endcase
            case (prof % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            if (prof == 5) hold_req++;
            prof++;
            repeat (3) push_problem(lp_rows, lp_cols);
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && solution_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0t errors %0d, results still expected %0d",
                     $time, errors, solution_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
